// ----- hw/rtl/bmm_pkg.sv -----
`default_nettype none

package bmm_pkg;

  // Fixed field widths
  localparam int ACT_W     = 2;
  localparam int IDX_IN_W  = 6;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = 40;
  localparam int POS_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_START   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_M  = 2'd0,
    REG_INNER_K = 2'd1,
    REG_COLS_N  = 2'd2
  } cfg_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd;
    logic             first;
    logic             last_term;
    logic             load_out;
    logic             out_last;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sum_ready;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmm_if.sv -----
`default_nettype none

interface bmm_item_if;
  logic                          valid;
  logic                          ready;
  logic [bmm_pkg::ACT_W-1:0]     action;
  logic [bmm_pkg::IDX_IN_W-1:0]  elem_index;
  logic signed [bmm_pkg::ELEM_W-1:0] elem_value;

  modport source (output valid, action, elem_index, elem_value, input ready);
  modport sink (input valid, action, elem_index, elem_value, output ready);
endinterface

interface bmm_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [bmm_pkg::SUM_W-1:0] sum_value;
  logic [bmm_pkg::POS_W-1:0]        out_row;
  logic [bmm_pkg::POS_W-1:0]        out_col;
  logic                             last;

  modport source (output valid, sum_value, out_row, out_col, last, input ready);
  modport sink (input valid, sum_value, out_row, out_col, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bmm_ram.sv -----
`default_nettype none

module bmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bmm_datapath.sv -----
`default_nettype none

module bmm_datapath #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire bmm_pkg::dp_cmd_t                     cmd,
  output bmm_pkg::dp_stat_t                         stat,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr,
  input  wire logic signed [bmm_pkg::ELEM_W-1:0]    wr_data,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   rd_addr_a,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   rd_addr_b,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [bmm_pkg::SUM_W-1:0]          out_sum,
  output logic [bmm_pkg::POS_W-1:0]                 out_row,
  output logic [bmm_pkg::POS_W-1:0]                 out_col,
  output logic                                      out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int EW    = bmm_pkg::ELEM_W;
  localparam int PW    = bmm_pkg::PROD_W;
  localparam int SW    = bmm_pkg::SUM_W;

  logic [EW-1:0]        a_q;
  logic [EW-1:0]        b_q;
  logic                 v1, f1, l1;
  logic                 v2, f2, l2;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] prod_ext;
  logic signed [SW-1:0] acc;
  logic                 sum_ready;

  bmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_a),
    .rdata (a_q)
  );

  bmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_b),
    .rdata (b_q)
  );

  // Track term valid through read and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd;
      v2 <= v1;
    end
  end

  // Multiply, then accumulate exactly
  assign prod_ext = {{(SW-PW){prod[PW-1]}}, prod};

  always_ff @(posedge clk) begin
    f1   <= cmd.first;
    l1   <= cmd.last_term;
    f2   <= f1;
    l2   <= l1;
    prod <= $signed(a_q) * $signed(b_q);
    if (v2) begin
      acc <= f2 ? prod_ext : acc + prod_ext;
    end
  end

  // Flag a finished sum until it moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ready <= 1'b0;
    end else if (v2 && l2) begin
      sum_ready <= 1'b1;
    end else if (cmd.load_out) begin
      sum_ready <= 1'b0;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sum  <= acc;
      out_row  <= cmd.out_row;
      out_col  <= cmd.out_col;
      out_last <= cmd.out_last;
    end
  end

  assign stat.sum_ready = sum_ready;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/bmm_ctrl.sv -----
`default_nettype none

module bmm_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bmm_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [bmm_pkg::ACT_W-1:0]           in_action,
  input  wire logic [bmm_pkg::IDX_IN_W-1:0]        in_index,
  input  wire bmm_pkg::dp_stat_t                   stat,
  output bmm_pkg::dp_cmd_t                         cmd,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       wr_addr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       rd_addr_a,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       rd_addr_b
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = bmm_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t           state;
  logic [CW-1:0]    rows_m, inner_k, cols_n;
  logic [DW-1:0]    m_eff, k_eff, n_eff;
  logic [IW-1:0]    i, j, t;
  logic [AW-1:0]    a_row;
  logic [AW-1:0]    b_ptr;
  logic             accept;
  logic             in_store;
  logic             last_t;
  logic             last_i;
  logic             last_j;
  bmm_pkg::action_t act;

  function automatic logic [DW-1:0] eff_dim(input logic [CW-1:0] r);
    logic [DW-1:0] d;
    if (r == '0) begin
      d = DW'(1);
    end else if (32'(r) > MAX_DIM) begin
      d = DW'(MAX_DIM);
    end else begin
      d = DW'(r);
    end
    return d;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= bmm_pkg::DIM_RESET;
      inner_k <= bmm_pkg::DIM_RESET;
      cols_n  <= bmm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (bmm_pkg::cfg_reg_t'(cfg_index))
        bmm_pkg::REG_ROWS_M:  rows_m  <= cfg_data;
        bmm_pkg::REG_INNER_K: inner_k <= cfg_data;
        bmm_pkg::REG_COLS_N:  cols_n  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m_eff = eff_dim(rows_m);
  assign k_eff = eff_dim(inner_k);
  assign n_eff = eff_dim(cols_n);

  assign act      = bmm_pkg::action_t'(in_action);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_store = 32'(in_index) < DEPTH;
  assign last_t   = DW'(t) == k_eff - DW'(1);
  assign last_i   = DW'(i) == m_eff - DW'(1);
  assign last_j   = DW'(j) == n_eff - DW'(1);

  // Sequence rows, columns and terms
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && act == bmm_pkg::ACT_START) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (last_t) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (stat.sum_ready && stat.out_free) begin
            state <= (last_i && last_j) ? S_IDLE : S_RUN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        i     <= '0;
        j     <= '0;
        t     <= '0;
        a_row <= '0;
        b_ptr <= '0;
      end
      S_RUN: begin
        if (last_t) begin
          t <= '0;
        end else begin
          t     <= t + IW'(1);
          b_ptr <= b_ptr + AW'(n_eff);
        end
      end
      S_WAIT: begin
        if (stat.sum_ready && stat.out_free) begin
          if (last_j) begin
            j     <= '0;
            i     <= i + IW'(1);
            a_row <= a_row + AW'(k_eff);
            b_ptr <= '0;
          end else begin
            j     <= j + IW'(1);
            b_ptr <= AW'(j) + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Store writes come straight from accepted requests
  assign wr_addr   = AW'(in_index);
  assign rd_addr_a = a_row + AW'(t);
  assign rd_addr_b = b_ptr;

  always_comb begin
    cmd           = '0;
    cmd.wr_a      = accept && in_store && act == bmm_pkg::ACT_WRITE_A;
    cmd.wr_b      = accept && in_store && act == bmm_pkg::ACT_WRITE_B;
    cmd.rd        = (state == S_RUN);
    cmd.first     = (t == '0);
    cmd.last_term = last_t;
    cmd.load_out  = (state == S_WAIT) && stat.sum_ready && stat.out_free;
    cmd.out_last  = last_i && last_j;
    cmd.out_row   = bmm_pkg::POS_W'(i);
    cmd.out_col   = bmm_pkg::POS_W'(j);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/batched_matrix_multiply_unit.sv -----
// Element writes: one request per cycle while idle, no result.
// Start: blocks input until the last of the M*N results is loaded; each result element takes
// K store reads through the single multiply-accumulate unit plus the read, multiply and
// accumulate registers, and a held output register adds its stalls.
// First result is registered once its last term has passed the accumulate register.
// Reset clears control state and sets rows_m, inner_k and cols_n to 8; stores keep contents.
`default_nettype none

module batched_matrix_multiply_unit #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  bmm_item_if.sink                               item,
  bmm_result_if.source                           result,
  input  wire logic                              cfg_we,
  input  wire logic [bmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bmm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  bmm_pkg::dp_cmd_t  cmd;
  bmm_pkg::dp_stat_t stat;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;

  bmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_action (item.action),
    .in_index  (item.elem_index),
    .stat      (stat),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b)
  );

  bmm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .wr_addr   (wr_addr),
    .wr_data   (item.elem_value),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_sum   (result.sum_value),
    .out_row   (result.out_row),
    .out_col   (result.out_col),
    .out_last  (result.last)
  );

endmodule

`default_nettype wire
